/* rtl/ptm_pkg.sv */
// Shared types and constants for the pose to transform matrix block.
`timescale 1ns / 1ps
package ptm_pkg;

  // Q16.16 one
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  // quotient bits kept by the divider: Q16.16 plus one rounding bit, values up to 2^17
  localparam int QUO_BITS = 18;

  // last matrix row index
  localparam logic [1:0] LAST_ROW = 2'd3;

  // per-row control that travels alongside the divider lanes
  typedef struct packed {
    logic [1:0]  row;
    logic        fell;
    logic        last;
    logic [31:0] col3;
  } row_info_t;

endpackage

/* rtl/ptm_front.sv */
// Front pipeline: products, rotation numerators, squared norm and degenerate check.
`timescale 1ns / 1ps
module ptm_front #(
  parameter int QUAT_WIDTH = 16,
  parameter int POS_WIDTH  = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [POS_WIDTH-1:0]   pos_x,
  input  logic signed [POS_WIDTH-1:0]   pos_y,
  input  logic signed [POS_WIDTH-1:0]   pos_z,
  input  logic signed [QUAT_WIDTH-1:0]  quat_x,
  input  logic signed [QUAT_WIDTH-1:0]  quat_y,
  input  logic signed [QUAT_WIDTH-1:0]  quat_z,
  input  logic signed [QUAT_WIDTH-1:0]  quat_w,
  input  logic [31:0]                   min_norm_squared,
  output logic                          out_valid,
  output logic [8:0][2*QUAT_WIDTH+1:0]  num,
  output logic [8:0]                    neg,
  output logic [2*QUAT_WIDTH:0]         den,
  output logic                          fell,
  output logic [2:0][31:0]              pos
);
  import ptm_pkg::*;

  localparam int PW    = 2 * QUAT_WIDTH;
  localparam int SW    = 2 * QUAT_WIDTH + 2;
  localparam int NW    = 2 * QUAT_WIDTH + 1;
  localparam int FRAC2 = 2 * QUAT_WIDTH - 4;
  localparam int CW    = 2 * QUAT_WIDTH + 33;
  localparam int EW    = (POS_WIDTH > 32) ? POS_WIDTH : 33;
  localparam logic signed [EW-1:0] PMAX = {{(EW-32){1'b0}}, 32'h7FFF_FFFF};
  localparam logic signed [EW-1:0] PMIN = {{(EW-32){1'b1}}, 32'h8000_0000};

  // stage 1: registered inputs, position clamped to 32 bits
  logic                         v1;
  logic signed [QUAT_WIDTH-1:0] qx, qy, qz, qw;
  logic [2:0][31:0]             pos1;
  logic signed [EW-1:0]         pext [3];
  logic [2:0][31:0]             psat;

  always_comb begin
    pext[0] = EW'(pos_x);
    pext[1] = EW'(pos_y);
    pext[2] = EW'(pos_z);
    for (int i = 0; i < 3; i++) begin
      if (pext[i] > PMAX) psat[i] = 32'h7FFF_FFFF;
      else if (pext[i] < PMIN) psat[i] = 32'h8000_0000;
      else psat[i] = pext[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
    if (en) begin
      qx <= quat_x;
      qy <= quat_y;
      qz <= quat_z;
      qw <= quat_w;
      pos1 <= psat;
    end
  end

  // stage 2: the ten component products
  logic                 v2;
  logic signed [PW-1:0] xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
  logic [2:0][31:0]     pos2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      xx <= qx * qx;
      yy <= qy * qy;
      zz <= qz * qz;
      ww <= qw * qw;
      xy <= qx * qy;
      xz <= qx * qz;
      yz <= qy * qz;
      wx <= qw * qx;
      wy <= qw * qy;
      wz <= qw * qz;
      pos2 <= pos1;
    end
  end

  // stage 3: signed numerators and squared norm
  logic                 v3;
  logic signed [SW-1:0] e [9];
  logic [NW-1:0]        n2;
  logic [2:0][31:0]     pos3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      e[0] <= SW'(ww) + SW'(xx) - SW'(yy) - SW'(zz);
      e[1] <= SW'(xy) - SW'(wz);
      e[2] <= SW'(xz) + SW'(wy);
      e[3] <= SW'(xy) + SW'(wz);
      e[4] <= SW'(ww) + SW'(yy) - SW'(xx) - SW'(zz);
      e[5] <= SW'(yz) - SW'(wx);
      e[6] <= SW'(xz) - SW'(wy);
      e[7] <= SW'(yz) + SW'(wx);
      e[8] <= SW'(ww) + SW'(zz) - SW'(xx) - SW'(yy);
      n2   <= NW'(unsigned'(xx)) + NW'(unsigned'(yy))
            + NW'(unsigned'(zz)) + NW'(unsigned'(ww));
      pos3 <= pos2;
    end
  end

  // stage 4: magnitudes (off-diagonal doubled) and threshold compare
  logic [CW-1:0] n2_cmp, mns_cmp;
  logic          fell_c;

  generate
    if (FRAC2 >= 28) begin : g_cmp_hi
      assign n2_cmp  = CW'(n2);
      assign mns_cmp = CW'(min_norm_squared) << (FRAC2 - 28);
    end else begin : g_cmp_lo
      assign n2_cmp  = CW'(n2) << (28 - FRAC2);
      assign mns_cmp = CW'(min_norm_squared);
    end
  endgenerate

  assign fell_c = (n2_cmp <= mns_cmp);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v3;
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        neg[i] <= e[i][SW-1];
        if (i % 4 == 0) num[i] <= e[i][SW-1] ? SW'(-e[i]) : SW'(e[i]);
        else num[i] <= (e[i][SW-1] ? SW'(-e[i]) : SW'(e[i])) << 1;
      end
      den  <= n2;
      fell <= fell_c;
      pos  <= pos3;
    end
  end

endmodule

/* rtl/ptm_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with a tag that rides along.
`timescale 1ns / 1ps
module ptm_div #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 33,
  parameter int TAG_W = 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [NUM_W-1:0]                num,
  input  logic [DEN_W-1:0]                den,
  input  logic [TAG_W-1:0]                tag,
  output logic                            out_valid,
  output logic [ptm_pkg::QUO_BITS-1:0]    quo,
  output logic [TAG_W-1:0]                out_tag
);
  import ptm_pkg::*;

  localparam int RW = NUM_W + QUO_BITS - 1;

  logic                vld  [QUO_BITS+1];
  logic [RW-1:0]       rem  [QUO_BITS+1];
  logic [QUO_BITS-1:0] qacc [QUO_BITS+1];
  logic [DEN_W-1:0]    dreg [QUO_BITS+1];
  logic [TAG_W-1:0]    treg [QUO_BITS+1];

  // dividend is the numerator scaled by 2^(QUO_BITS-1)
  assign vld[0]  = in_valid;
  assign rem[0]  = {num, {(QUO_BITS-1){1'b0}}};
  assign qacc[0] = '0;
  assign dreg[0] = den;
  assign treg[0] = tag;

  generate
    for (genvar s = 0; s < QUO_BITS; s++) begin : g_stage
      localparam int K = QUO_BITS - 1 - s;
      logic [RW-1:0] dsh;
      logic          take;

      // trial subtract of the divisor aligned to this quotient bit
      assign dsh  = RW'(dreg[s]) << K;
      assign take = (rem[s] >= dsh);

      always_ff @(posedge clk) begin
        if (rst) vld[s+1] <= 1'b0;
        else if (en) vld[s+1] <= vld[s];
        if (en) begin
          rem[s+1]  <= take ? rem[s] - dsh : rem[s];
          qacc[s+1] <= {qacc[s][QUO_BITS-2:0], take};
          dreg[s+1] <= dreg[s];
          treg[s+1] <= treg[s];
        end
      end
    end
  endgenerate

  assign out_valid = vld[QUO_BITS];
  assign quo       = qacc[QUO_BITS];
  assign out_tag   = treg[QUO_BITS];

endmodule

/* rtl/pose_to_transform_matrix.sv */
// Top level: pose in, four Q16.16 rows of the rigid transform out.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------
//   input    | in_valid / in_ready    | pos_x pos_y pos_z quat_x quat_y quat_z quat_w
//   result   | out_valid / out_ready  | row_index col0..col3 fell_back last
//   config   | cfg_we                 | cfg_wdata -> min_norm_squared
//
// A new pose is taken only when the row issuer is empty or on its last row; the
// issuer sends one row per cycle, unless stalled, into three divider lanes. The
// path is 4 front stages, the issuer, QUO_BITS divider stages, an output register.
// rst clears all valid bits and min_norm_squared; a result stall freezes all stages.
`timescale 1ns / 1ps
module pose_to_transform_matrix #(
  parameter int QUAT_WIDTH = 16,
  parameter int POS_WIDTH  = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [POS_WIDTH-1:0]   pos_x,
  input  logic signed [POS_WIDTH-1:0]   pos_y,
  input  logic signed [POS_WIDTH-1:0]   pos_z,
  input  logic signed [QUAT_WIDTH-1:0]  quat_x,
  input  logic signed [QUAT_WIDTH-1:0]  quat_y,
  input  logic signed [QUAT_WIDTH-1:0]  quat_z,
  input  logic signed [QUAT_WIDTH-1:0]  quat_w,
  input  logic                          cfg_we,
  input  logic [31:0]                   cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    row_index,
  output logic signed [31:0]            col0,
  output logic signed [31:0]            col1,
  output logic signed [31:0]            col2,
  output logic signed [31:0]            col3,
  output logic                          fell_back,
  output logic                          last
);
  import ptm_pkg::*;

  localparam int SW = 2 * QUAT_WIDTH + 2;
  localparam int NW = 2 * QUAT_WIDTH + 1;
  localparam int IW = $bits(row_info_t);

  // threshold register
  logic [31:0] min_norm_squared;

  always_ff @(posedge clk) begin
    if (rst) min_norm_squared <= '0;
    else if (cfg_we) min_norm_squared <= cfg_wdata;
  end

  // global advance: everything moves unless a result is held; the front also waits while the row issuer is busy
  logic en, fen;
  logic hv;
  logic [1:0] rc;

  assign en       = !out_valid || out_ready;
  assign fen      = en && (!hv || rc == LAST_ROW);
  assign in_ready = fen;

  // front pipeline
  logic              f_valid;
  logic [8:0][SW-1:0] f_num;
  logic [8:0]        f_neg;
  logic [NW-1:0]     f_den;
  logic              f_fell;
  logic [2:0][31:0]  f_pos;

  ptm_front #(.QUAT_WIDTH(QUAT_WIDTH), .POS_WIDTH(POS_WIDTH)) u_front (
    .clk(clk), .rst(rst), .en(fen), .in_valid(in_valid),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
    .min_norm_squared(min_norm_squared),
    .out_valid(f_valid), .num(f_num), .neg(f_neg), .den(f_den),
    .fell(f_fell), .pos(f_pos)
  );

  // row issuer: holds one pose and sends a row per cycle while the result side does not stall
  logic [8:0][SW-1:0] h_num;
  logic [8:0]         h_neg;
  logic [NW-1:0]      h_den;
  logic               h_fell;
  logic [2:0][31:0]   h_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      hv <= 1'b0;
      rc <= '0;
    end else if (fen) begin
      hv <= f_valid;
      rc <= '0;
    end else if (en && hv) begin
      rc <= rc + 2'd1;
    end
    if (fen) begin
      h_num  <= f_num;
      h_neg  <= f_neg;
      h_den  <= f_den;
      h_fell <= f_fell;
      h_pos  <= f_pos;
    end
  end

  logic [2:0][SW-1:0] row_num;
  logic [2:0]         row_neg;
  row_info_t          row_info;

  always_comb begin
    row_info.row  = rc;
    row_info.fell = h_fell;
    row_info.last = (rc == LAST_ROW);
    row_info.col3 = ONE_Q16;
    row_num = '0;
    row_neg = '0;
    case (rc)
      2'd0: begin
        row_num = h_num[2:0];
        row_neg = h_neg[2:0];
        row_info.col3 = h_pos[0];
      end
      2'd1: begin
        row_num = h_num[5:3];
        row_neg = h_neg[5:3];
        row_info.col3 = h_pos[1];
      end
      2'd2: begin
        row_num = h_num[8:6];
        row_neg = h_neg[8:6];
        row_info.col3 = h_pos[2];
      end
      default: ;
    endcase
  end

  // three divider lanes, lane 0 carries the row info
  logic                d_valid;
  logic [2:0][QUO_BITS-1:0] d_quo;
  logic [IW:0]         d_tag0;
  logic [1:0]          d_tag12;
  logic [1:0]          d_valid12;

  ptm_div #(.NUM_W(SW), .DEN_W(NW), .TAG_W(IW + 1)) u_div0 (
    .clk(clk), .rst(rst), .en(en), .in_valid(hv),
    .num(row_num[0]), .den(h_den), .tag({row_neg[0], row_info}),
    .out_valid(d_valid), .quo(d_quo[0]), .out_tag(d_tag0)
  );

  ptm_div #(.NUM_W(SW), .DEN_W(NW), .TAG_W(1)) u_div1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(hv),
    .num(row_num[1]), .den(h_den), .tag(row_neg[1]),
    .out_valid(d_valid12[0]), .quo(d_quo[1]), .out_tag(d_tag12[0])
  );

  ptm_div #(.NUM_W(SW), .DEN_W(NW), .TAG_W(1)) u_div2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(hv),
    .num(row_num[2]), .den(h_den), .tag(row_neg[2]),
    .out_valid(d_valid12[1]), .quo(d_quo[2]), .out_tag(d_tag12[1])
  );

  // round, apply sign, substitute identity where needed
  row_info_t         o_info;
  logic [2:0]        o_neg;
  logic [2:0][31:0]  o_col;
  logic [QUO_BITS-1:0] rnd;

  assign o_info = d_tag0[IW-1:0];
  assign o_neg  = {d_tag12[1], d_tag12[0], d_tag0[IW]};

  always_comb begin
    rnd = '0;
    for (int j = 0; j < 3; j++) begin
      rnd = (d_quo[j] + QUO_BITS'(1)) >> 1;
      if (o_info.fell || o_info.row == LAST_ROW) begin
        o_col[j] = (o_info.row == 2'(j)) ? ONE_Q16 : 32'd0;
      end else begin
        o_col[j] = o_neg[j] ? -(32'(rnd)) : 32'(rnd);
      end
    end
  end

  // result register; the lanes move in lockstep
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= d_valid && d_valid12[0] && d_valid12[1];
    if (en) begin
      row_index <= o_info.row;
      col0      <= o_col[0];
      col1      <= o_col[1];
      col2      <= o_col[2];
      col3      <= o_info.col3;
      fell_back <= o_info.fell;
      last      <= o_info.last;
    end
  end

endmodule
